// ===== hw/rtl/tcw_pkg.sv =====
// shared types, constants and helpers for the congestion window engine
package tcw_pkg;

    localparam logic [31:0] ALL_ONES            = 32'hFFFF_FFFF;
    localparam logic [31:0] BYTE_LIMIT_RESET    = 32'd2097152;
    localparam logic [31:0] INIT_WINDOW_RESET   = 32'd10;
    localparam logic [31:0] WINDOW_CLAMP_RESET  = ALL_ONES;
    localparam logic [31:0] MIN_THRESHOLD       = 32'd2;
    localparam logic [1:0]  QUEUE_DEPTH         = 2'd2;

    typedef enum logic [1:0] {
        EV_OPEN = 2'd0,
        EV_ACK  = 2'd1,
        EV_LOSS = 2'd2,
        EV_NONE = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_BYTE_LIMIT     = 2'd0,
        CFG_INITIAL_WINDOW = 2'd1,
        CFG_WINDOW_CLAMP   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] una;
        logic [31:0] nxt;
    } t_event;

    typedef struct packed {
        logic        avail;
        t_event      ev;
    } t_evq_head;

    typedef struct packed {
        logic [31:0] byte_limit;
        logic [31:0] initial_window;
        logic [31:0] window_clamp;
    } t_cfg;

    typedef struct packed {
        logic [31:0] window;
        logic [31:0] threshold;
        logic [31:0] min_window;
        logic        turbo_on;
        logic        aggressive_on;
    } t_result;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? ALL_ONES : s[31:0];
    endfunction

endpackage

// ===== hw/rtl/tcw_front.sv =====
// input side: accepts events, decodes the kind and queues them for execution
module tcw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_req_type,
    input  logic [31:0]        i_una_seq,
    input  logic [31:0]        i_next_seq,
    output tcw_pkg::t_evq_head o_head,
    input  logic               i_head_pop
);

    tcw_pkg::t_event r_q [2];
    logic [1:0]      r_cnt, n_cnt;
    logic            r_wptr, r_rptr;
    logic            w_push_ok;
    logic            w_pop_ok;
    tcw_pkg::t_event w_ev;

    always_comb begin
        w_ev.kind = tcw_pkg::t_kind'(i_req_type);
        w_ev.una  = i_una_seq;
        w_ev.nxt  = i_next_seq;
    end

    assign full      = (r_cnt == tcw_pkg::QUEUE_DEPTH);
    assign w_push_ok = push && !full;
    assign w_pop_ok  = i_head_pop && (r_cnt != 2'd0);
    assign n_cnt     = r_cnt + {1'b0, w_push_ok} - {1'b0, w_pop_ok};

    assign o_head.avail = (r_cnt != 2'd0);
    assign o_head.ev    = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push_ok) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop_ok) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wptr] <= w_ev;
        end
    end

endmodule

// ===== hw/rtl/tcw_back.sv =====
// execution side: window state update and result queue
module tcw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcw_pkg::t_cfg      i_cfg,
    input  tcw_pkg::t_evq_head i_head,
    output logic               o_head_pop,
    output logic               empty,
    input  logic               pop,
    output tcw_pkg::t_result   o_result
);

    logic [31:0] r_cwnd, n_cwnd;
    logic [31:0] r_ssthresh, n_ssthresh;
    logic [31:0] r_ack_count, n_ack_count;
    logic [31:0] r_una_mark, n_una_mark;
    logic [31:0] r_next_mark, n_next_mark;
    logic [31:0] r_sent_total, n_sent_total;
    logic [31:0] r_acked_total, n_acked_total;
    logic        r_turbo, n_turbo;
    logic        r_aggressive, n_aggressive;

    tcw_pkg::t_result r_rq [2];
    logic [1:0]       r_cnt, n_cnt;
    logic             r_wptr, r_rptr;
    logic             w_exec;
    logic             w_pop_ok;
    logic [31:0]      w_sent_sum, w_acked_sum, w_loss_t;
    tcw_pkg::t_result w_res;

    assign w_exec     = i_head.avail && (r_cnt != tcw_pkg::QUEUE_DEPTH);
    assign o_head_pop = w_exec;
    assign w_pop_ok   = pop && (r_cnt != 2'd0);
    assign n_cnt      = r_cnt + {1'b0, w_exec} - {1'b0, w_pop_ok};
    assign empty      = (r_cnt == 2'd0);
    assign o_result   = r_rq[r_rptr];

    assign w_sent_sum  = r_sent_total + (i_head.ev.nxt - r_next_mark);
    assign w_acked_sum = r_acked_total + (i_head.ev.una - r_una_mark);
    assign w_loss_t    = r_turbo ? r_cwnd : {1'b0, r_cwnd[31:1]};

    always_comb begin
        n_cwnd        = r_cwnd;
        n_ssthresh    = r_ssthresh;
        n_ack_count   = r_ack_count;
        n_una_mark    = r_una_mark;
        n_next_mark   = r_next_mark;
        n_sent_total  = r_sent_total;
        n_acked_total = r_acked_total;
        n_turbo       = r_turbo;
        n_aggressive  = r_aggressive;
        unique case (i_head.ev.kind)
            tcw_pkg::EV_OPEN: begin
                n_cwnd        = i_cfg.initial_window;
                n_ssthresh    = tcw_pkg::ALL_ONES;
                n_ack_count   = 32'd0;
                n_sent_total  = 32'd0;
                n_acked_total = 32'd0;
                n_turbo       = 1'b1;
                n_aggressive  = 1'b1;
                n_una_mark    = i_head.ev.una;
                n_next_mark   = i_head.ev.nxt;
            end
            tcw_pkg::EV_ACK: begin
                if (r_aggressive) begin
                    n_sent_total = w_sent_sum;
                    n_next_mark  = i_head.ev.nxt;
                    n_aggressive = !(w_sent_sum > i_cfg.byte_limit);
                end
                if (r_turbo) begin
                    n_acked_total = w_acked_sum;
                    n_una_mark    = i_head.ev.una;
                    n_turbo       = !(w_acked_sum > i_cfg.byte_limit);
                end
                priority if (r_cwnd <= r_ssthresh && n_aggressive
                             && r_ssthresh == tcw_pkg::ALL_ONES) begin
                    n_cwnd = tcw_pkg::sat_add(r_cwnd, 32'd2);
                end else if (r_cwnd <= r_ssthresh) begin
                    n_cwnd = tcw_pkg::sat_add(r_cwnd, 32'd1);
                end else if (r_ack_count >= r_cwnd) begin
                    if (r_cwnd < i_cfg.window_clamp) begin
                        n_cwnd = r_cwnd + 32'd1;
                    end
                    n_ack_count = 32'd0;
                end else begin
                    n_ack_count = r_ack_count + 32'd1;
                end
            end
            tcw_pkg::EV_LOSS: begin
                n_ssthresh = (w_loss_t < tcw_pkg::MIN_THRESHOLD) ? tcw_pkg::MIN_THRESHOLD
                                                                 : w_loss_t;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_res.window        = n_cwnd;
        w_res.threshold     = n_ssthresh;
        w_res.min_window    = n_turbo ? tcw_pkg::sat_add(n_cwnd, 32'd1)
                                      : {1'b0, n_ssthresh[31:1]};
        w_res.turbo_on      = n_turbo;
        w_res.aggressive_on = n_aggressive;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cwnd        <= tcw_pkg::INIT_WINDOW_RESET;
            r_ssthresh    <= tcw_pkg::ALL_ONES;
            r_ack_count   <= 32'd0;
            r_una_mark    <= 32'd0;
            r_next_mark   <= 32'd0;
            r_sent_total  <= 32'd0;
            r_acked_total <= 32'd0;
            r_turbo       <= 1'b1;
            r_aggressive  <= 1'b1;
            r_cnt         <= 2'd0;
            r_wptr        <= 1'b0;
            r_rptr        <= 1'b0;
        end else begin
            if (w_exec) begin
                r_cwnd        <= n_cwnd;
                r_ssthresh    <= n_ssthresh;
                r_ack_count   <= n_ack_count;
                r_una_mark    <= n_una_mark;
                r_next_mark   <= n_next_mark;
                r_sent_total  <= n_sent_total;
                r_acked_total <= n_acked_total;
                r_turbo       <= n_turbo;
                r_aggressive  <= n_aggressive;
                r_wptr        <= ~r_wptr;
            end
            if (w_pop_ok) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_rq[r_wptr] <= w_res;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tcw_pkg::QUEUE_DEPTH)
        else $error("result queue overfilled");

    a_open_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && i_head.ev.kind == tcw_pkg::EV_OPEN)
        |=> (r_turbo && r_aggressive && r_ssthresh == tcw_pkg::ALL_ONES
             && r_sent_total == 32'd0 && r_acked_total == 32'd0))
        else $error("open event did not rearm state");

    a_loss_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && i_head.ev.kind == tcw_pkg::EV_LOSS)
        |=> (r_ssthresh >= tcw_pkg::MIN_THRESHOLD && $stable(r_cwnd)))
        else $error("loss event broke threshold floor or window");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_exec |=> ($stable(r_cwnd) && $stable(r_ssthresh)))
        else $error("state changed without an executed event");

endmodule

// ===== hw/rtl/tcp_congestion_window_update.sv =====
// top level of the congestion window engine: configuration registers and queue wiring
// Takes one event per clock while full is low and returns one result per event. Events
// wait in the two-entry event queue until the result queue has room to execute them;
// each result is then registered in the result queue and can be popped. The window state
// is updated once per executed event; the sustained rate is one event per clock as long
// as results are popped. Both queues hold two entries each; with the result queue full
// and no pop the event queue fills and full rises. Configuration writes are always ready
// and take effect at once; an index past the last register is ignored.
module tcp_congestion_window_update (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_una_seq,
    input  logic [31:0] i_next_seq,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_window,
    output logic [31:0] o_threshold,
    output logic [31:0] o_min_window,
    output logic        o_turbo_on,
    output logic        o_aggressive_on,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    tcw_pkg::t_cfg      r_cfg;
    tcw_pkg::t_evq_head w_head;
    tcw_pkg::t_result   w_result;
    logic               w_head_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.byte_limit     <= tcw_pkg::BYTE_LIMIT_RESET;
            r_cfg.initial_window <= tcw_pkg::INIT_WINDOW_RESET;
            r_cfg.window_clamp   <= tcw_pkg::WINDOW_CLAMP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tcw_pkg::CFG_BYTE_LIMIT:     r_cfg.byte_limit     <= i_cfg_data;
                tcw_pkg::CFG_INITIAL_WINDOW: r_cfg.initial_window <= i_cfg_data;
                tcw_pkg::CFG_WINDOW_CLAMP:   r_cfg.window_clamp   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req_type (i_req_type),
        .i_una_seq  (i_una_seq),
        .i_next_seq (i_next_seq),
        .o_head     (w_head),
        .i_head_pop (w_head_pop)
    );

    tcw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (w_head),
        .o_head_pop (w_head_pop),
        .empty      (empty),
        .pop        (pop),
        .o_result   (w_result)
    );

    assign o_window        = w_result.window;
    assign o_threshold     = w_result.threshold;
    assign o_min_window    = w_result.min_window;
    assign o_turbo_on      = w_result.turbo_on;
    assign o_aggressive_on = w_result.aggressive_on;

endmodule
